@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/ofdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ofdr_pkg
// shared types, constants and angle helpers of the dead-reckoning block
// ----------------------------------------------------------------------------
`default_nettype none

package ofdr_pkg;

    // internal angle resolution and position fraction
    localparam int ANGLE_BITS    = 16;
    localparam int POS_FRAC_BITS = 16;

    localparam int EXT_ANGLE_BITS = 16;
    localparam int POS_BITS       = 48;
    localparam int FLOW_BITS      = 16;
    localparam int CS_BITS        = 32;
    localparam int PROD_BITS      = FLOW_BITS + CS_BITS;

    localparam int UP_SHIFT   = (ANGLE_BITS >= EXT_ANGLE_BITS) ? ANGLE_BITS - EXT_ANGLE_BITS : 0;
    localparam int DOWN_SHIFT = (ANGLE_BITS >= EXT_ANGLE_BITS) ? 0 : EXT_ANGLE_BITS - ANGLE_BITS;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
    localparam logic signed [CS_BITS-1:0] CORDIC_GAIN = 32'sd652032874;

    // q30 products down to the position fraction, round half up
    localparam int RND_SHIFT = 30 - POS_FRAC_BITS;
    localparam logic signed [PROD_BITS:0] RND_HALF =
        (RND_SHIFT == 0) ? '0 : (PROD_BITS+1)'(64'd1 << ((RND_SHIFT == 0) ? 0 : RND_SHIFT - 1));

    localparam logic signed [EXT_ANGLE_BITS-1:0] MOUNT_RESET = -16'sd602;

    localparam int IN_TDATA_BITS  = 96;
    localparam int IN_TUSER_BITS  = 3;
    localparam int OUT_TDATA_BITS = 112;

    typedef enum logic [1:0] {
        MODE_SAMPLE      = 2'd0,
        MODE_SET_X       = 2'd1,
        MODE_SET_Y       = 2'd2,
        MODE_SET_HEADING = 2'd3
    } mode_t;

    // per-item payload that rides along the rotation chain
    typedef struct packed {
        mode_t                         mode;
        logic                          acc_en;
        logic                          flip;
        logic signed [FLOW_BITS-1:0]   dx;
        logic signed [FLOW_BITS-1:0]   dy;
        logic signed [POS_BITS-1:0]    set_value;
        logic [ANGLE_BITS-1:0]         heading;
    } item_t;

    typedef struct packed {
        logic signed [CS_BITS-1:0] x;
        logic signed [CS_BITS-1:0] y;
        logic signed [CS_BITS-1:0] z;
    } cord_t;

    // arctangent of 2^-i as a 32-bit turn
    function automatic logic signed [CS_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] step);
        logic signed [CS_BITS-1:0] r;
        case (step)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000029;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            5'd28:   r = 32'h00000003;
            5'd29:   r = 32'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    // 16-bit binary angle to internal resolution
    function automatic logic [ANGLE_BITS-1:0] angle_in(input logic [EXT_ANGLE_BITS-1:0] v);
        logic [ANGLE_BITS+EXT_ANGLE_BITS-1:0] w;
        w = {{ANGLE_BITS{1'b0}}, v} << UP_SHIFT;
        w = w >> DOWN_SHIFT;
        return w[ANGLE_BITS-1:0];
    endfunction

    // internal angle back to a 16-bit binary angle
    function automatic logic [EXT_ANGLE_BITS-1:0] angle_out(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS+EXT_ANGLE_BITS-1:0] w;
        w = {{EXT_ANGLE_BITS{1'b0}}, a} >> UP_SHIFT;
        w = w << DOWN_SHIFT;
        return w[EXT_ANGLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/optical_flow_dead_reckoning.sv @@
// ----------------------------------------------------------------------------
// optical_flow_dead_reckoning
// rotates optical-flow steps by the imu heading and accumulates position
// ----------------------------------------------------------------------------
//
//  channel   | dir | contents (lowest bit first)
//  ----------+-----+------------------------------------------------------------
//  s_axis    | in  | tdata: yaw_angle, flow_dx, flow_dy, set_value
//            |     | tuser: mode, flow_valid
//  m_axis    | out | tdata: pos_x, pos_y, heading_angle
//  cfg_wr    | in  | mount_offset_angle, written whenever cfg_wr_en is high
//
//  one transaction per cycle sustained while the output is taken; the path from
//  input to result runs through the 30 cordic cells plus four tail stages
//  every stage holds its own valid bit, so bubbles are squeezed out and input
//  is only refused once every stage and the output register are full
//  reset (rst_n low, asynchronous) empties the pipe, clears the position and
//  heading state and loads the mounting angle default
//
`default_nettype none

`include "assert_macros.svh"

module optical_flow_dead_reckoning (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    // input item stream
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // yaw_angle[15:0], flow_dx[31:16], flow_dy[47:32], set_value[95:48]
    input  wire logic [ofdr_pkg::IN_TDATA_BITS-1:0]         s_axis_tdata,
    // mode[1:0], flow_valid[2]
    input  wire logic [ofdr_pkg::IN_TUSER_BITS-1:0]         s_axis_tuser,
    // result stream
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // pos_x[47:0], pos_y[95:48], heading_angle[111:96]
    output logic [ofdr_pkg::OUT_TDATA_BITS-1:0]             m_axis_tdata,
    // mounting angle register
    input  wire logic                                       cfg_wr_en,
    input  wire logic [ofdr_pkg::EXT_ANGLE_BITS-1:0]        cfg_wr_data
);

    localparam int AB = ofdr_pkg::ANGLE_BITS;
    localparam int CB = ofdr_pkg::CS_BITS;
    localparam int NS = ofdr_pkg::CORDIC_STEPS;

    // unpacked input fields
    ofdr_pkg::mode_t                            in_mode;
    logic                                       in_flow_valid;
    logic [ofdr_pkg::EXT_ANGLE_BITS-1:0]        in_yaw;
    logic signed [ofdr_pkg::FLOW_BITS-1:0]      in_dx;
    logic signed [ofdr_pkg::FLOW_BITS-1:0]      in_dy;
    logic signed [ofdr_pkg::POS_BITS-1:0]       in_set;

    assign in_mode       = ofdr_pkg::mode_t'(s_axis_tuser[1:0]);
    assign in_flow_valid = s_axis_tuser[2];
    assign in_yaw        = s_axis_tdata[15:0];
    assign in_dx         = s_axis_tdata[31:16];
    assign in_dy         = s_axis_tdata[47:32];
    assign in_set        = s_axis_tdata[95:48];

    // heading state, updated as each transaction is accepted
    logic [ofdr_pkg::EXT_ANGLE_BITS-1:0]    mount_reg;
    logic [AB-1:0]                          ref_reg;
    logic [AB-1:0]                          ref_next;
    logic [AB-1:0]                          last_raw_reg;
    logic [AB-1:0]                          last_raw_next;
    logic [AB-1:0]                          heading_reg;
    logic [AB-1:0]                          heading_next;
    logic                                   taken_reg;
    logic                                   taken_next;

    logic                                   s_acc;
    logic [AB-1:0]                          raw;
    logic [AB-1:0]                          ref_eff;
    logic [AB-1:0]                          rot;
    logic [CB-1:0]                          turn;
    logic [CB-1:0]                          turn_q;
    logic                                   flip;

    // chain wiring, index 0 is the input side
    logic                                   ch_valid [NS+1];
    logic                                   ch_ready [NS+1];
    ofdr_pkg::item_t                        ch_item  [NS+1];
    ofdr_pkg::cord_t                        ch_cord  [NS+1];

    logic signed [ofdr_pkg::POS_BITS-1:0]   out_pos_x;
    logic signed [ofdr_pkg::POS_BITS-1:0]   out_pos_y;
    logic [ofdr_pkg::EXT_ANGLE_BITS-1:0]    out_heading;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // the first sample latches the yaw reference, so its heading is zero
    assign raw     = ofdr_pkg::angle_in(in_yaw);
    assign ref_eff = taken_reg ? ref_reg : raw;

    always_comb
    begin
        ref_next      = ref_reg;
        last_raw_next = last_raw_reg;
        heading_next  = heading_reg;
        taken_next    = taken_reg;
        unique case (in_mode) inside
            ofdr_pkg::MODE_SAMPLE:
            begin
                ref_next      = ref_eff;
                last_raw_next = raw;
                heading_next  = raw - ref_eff;
                taken_next    = 1'b1;
            end
            ofdr_pkg::MODE_SET_HEADING:
            begin
                // heading output only moves with the next sample
                ref_next = last_raw_reg - ofdr_pkg::angle_in(in_set[15:0]);
            end
            ofdr_pkg::MODE_SET_X, ofdr_pkg::MODE_SET_Y: ;
            default: ;
        endcase
    end

    // rotation angle as a 32-bit turn, folded into plus or minus a quarter
    always_comb
    begin
        rot    = heading_next + ofdr_pkg::angle_in(mount_reg);
        turn   = {rot, {(CB-AB){1'b0}}};
        turn_q = turn + 32'h4000_0000;
        flip   = turn_q[CB-1];
    end

    always_comb
    begin
        ch_item[0].mode      = in_mode;
        ch_item[0].acc_en    = (in_mode == ofdr_pkg::MODE_SAMPLE) && in_flow_valid;
        ch_item[0].flip      = flip;
        ch_item[0].dx        = in_dx;
        ch_item[0].dy        = in_dy;
        ch_item[0].set_value = in_set;
        ch_item[0].heading   = heading_next;
        ch_cord[0].x         = ofdr_pkg::CORDIC_GAIN;
        ch_cord[0].y         = '0;
        ch_cord[0].z         = flip ? (turn + 32'h8000_0000) : turn;
    end

    assign ch_valid[0]   = s_axis_tvalid;
    assign s_axis_tready = ch_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_reg    <= ofdr_pkg::MOUNT_RESET;
            ref_reg      <= '0;
            last_raw_reg <= '0;
            heading_reg  <= '0;
            taken_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mount_reg <= cfg_wr_data;
            end
            if (s_acc)
            begin
                ref_reg      <= ref_next;
                last_raw_reg <= last_raw_next;
                heading_reg  <= heading_next;
                taken_reg    <= taken_next;
            end
        end
    end

    // row of cordic cells, one rotation step each
    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        ofdr_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (ofdr_pkg::STEP_BITS'(i)),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_item   (ch_item[i]),
            .in_cord   (ch_cord[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_item  (ch_item[i+1]),
            .out_cord  (ch_cord[i+1])
        );
    end

    // rotate, round and accumulate, output register included
    ofdr_rotate_acc u_tail (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (ch_valid[NS]),
        .in_ready      (ch_ready[NS]),
        .in_item       (ch_item[NS]),
        .in_cord       (ch_cord[NS]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pos_x         (out_pos_x),
        .pos_y         (out_pos_y),
        .heading_angle (out_heading)
    );

    assign m_axis_tdata = {out_heading, out_pos_y, out_pos_x};

    // once a reference is taken it stays taken
    `ASSERT_NEVER(a_taken_sticky, clk, rst_n, $fell(taken_reg))
    // the very first sample always yields a zero heading
    `ASSERT_CLK(a_first_zero, clk, rst_n,
        s_acc && (in_mode == ofdr_pkg::MODE_SAMPLE) && !taken_reg |=> heading_reg == '0)
    // a heading set leaves the reported heading alone
    `ASSERT_CLK(a_set_keeps, clk, rst_n,
        s_acc && (in_mode == ofdr_pkg::MODE_SET_HEADING) |=> $stable(heading_reg))
    // input is only refused while a result is waiting at the output
    `ASSERT_CLK(a_ready_pipe, clk, rst_n, !s_axis_tready |-> m_axis_tvalid)

endmodule

`default_nettype wire

@@ sv/ofdr_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ofdr_cordic_cell
// one registered cordic rotation step with its own valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

module ofdr_cordic_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [ofdr_pkg::STEP_BITS-1:0]    step,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire ofdr_pkg::item_t                   in_item,
    input  wire ofdr_pkg::cord_t                   in_cord,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output ofdr_pkg::item_t                        out_item,
    output ofdr_pkg::cord_t                        out_cord
);

    logic                  valid_reg;
    ofdr_pkg::item_t       item_reg;
    ofdr_pkg::cord_t       cord_reg;
    ofdr_pkg::cord_t       cord_next;
    logic signed [ofdr_pkg::CS_BITS-1:0] xs;
    logic signed [ofdr_pkg::CS_BITS-1:0] ys;
    logic signed [ofdr_pkg::CS_BITS-1:0] ang;

    // stage takes a new item when empty or when its item moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_cord  = cord_reg;

    always_comb
    begin
        xs  = in_cord.x >>> step;
        ys  = in_cord.y >>> step;
        ang = ofdr_pkg::atan_turn(step);
        if (!in_cord.z[ofdr_pkg::CS_BITS-1])
        begin
            cord_next.x = in_cord.x - ys;
            cord_next.y = in_cord.y + xs;
            cord_next.z = in_cord.z - ang;
        end
        else
        begin
            cord_next.x = in_cord.x + ys;
            cord_next.y = in_cord.y - xs;
            cord_next.z = in_cord.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
            cord_reg <= cord_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ofdr_rotate_acc.sv @@
// ----------------------------------------------------------------------------
// ofdr_rotate_acc
// unfolds cos/sin, rotates the flow step, rounds and accumulates position
// ----------------------------------------------------------------------------
`default_nettype none

module ofdr_rotate_acc (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire ofdr_pkg::item_t                        in_item,
    input  wire ofdr_pkg::cord_t                        in_cord,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [ofdr_pkg::POS_BITS-1:0]        pos_x,
    output logic signed [ofdr_pkg::POS_BITS-1:0]        pos_y,
    output logic [ofdr_pkg::EXT_ANGLE_BITS-1:0]         heading_angle
);

    localparam int PB = ofdr_pkg::PROD_BITS;
    localparam int QB = ofdr_pkg::POS_BITS;

    // stage a: signed cos/sin
    logic                                   a_valid_reg;
    ofdr_pkg::item_t                        a_item_reg;
    logic signed [ofdr_pkg::CS_BITS-1:0]    a_cos_reg;
    logic signed [ofdr_pkg::CS_BITS-1:0]    a_sin_reg;
    // stage b: products
    logic                                   b_valid_reg;
    ofdr_pkg::item_t                        b_item_reg;
    logic signed [PB-1:0]                   b_dxc_reg;
    logic signed [PB-1:0]                   b_dys_reg;
    logic signed [PB-1:0]                   b_dxs_reg;
    logic signed [PB-1:0]                   b_dyc_reg;
    // stage c: rounded rotated step
    logic                                   c_valid_reg;
    ofdr_pkg::item_t                        c_item_reg;
    logic signed [QB-1:0]                   c_rx_reg;
    logic signed [QB-1:0]                   c_ry_reg;
    // output register doubles as the accumulator
    logic                                   o_valid_reg;
    logic signed [QB-1:0]                   x_acc_reg;
    logic signed [QB-1:0]                   y_acc_reg;
    logic [ofdr_pkg::ANGLE_BITS-1:0]        heading_reg;
    logic signed [QB-1:0]                   x_acc_next;
    logic signed [QB-1:0]                   y_acc_next;

    logic a_ready, b_ready, c_ready, o_ready;
    logic signed [PB:0] sum_x;
    logic signed [PB:0] sum_y;
    logic signed [PB:0] rnd_x;
    logic signed [PB:0] rnd_y;

    assign o_ready  = !o_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || o_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        sum_x = (PB+1)'(b_dxc_reg) - (PB+1)'(b_dys_reg);
        sum_y = (PB+1)'(b_dxs_reg) + (PB+1)'(b_dyc_reg);
        rnd_x = (sum_x + ofdr_pkg::RND_HALF) >>> ofdr_pkg::RND_SHIFT;
        rnd_y = (sum_y + ofdr_pkg::RND_HALF) >>> ofdr_pkg::RND_SHIFT;
    end

    // rotated x moves y backwards, rotated y moves x forwards
    always_comb
    begin
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        unique case (c_item_reg.mode) inside
            ofdr_pkg::MODE_SAMPLE:
            begin
                if (c_item_reg.acc_en)
                begin
                    x_acc_next = x_acc_reg + c_ry_reg;
                    y_acc_next = y_acc_reg - c_rx_reg;
                end
            end
            ofdr_pkg::MODE_SET_X:       x_acc_next = c_item_reg.set_value;
            ofdr_pkg::MODE_SET_Y:       y_acc_next = c_item_reg.set_value;
            ofdr_pkg::MODE_SET_HEADING: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= c_valid_reg;
            end
            if (c_valid_reg && o_ready)
            begin
                x_acc_reg <= x_acc_next;
                y_acc_reg <= y_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_item_reg <= in_item;
            a_cos_reg  <= in_item.flip ? -in_cord.x : in_cord.x;
            a_sin_reg  <= in_item.flip ? -in_cord.y : in_cord.y;
        end
        if (a_valid_reg && b_ready)
        begin
            b_item_reg <= a_item_reg;
            b_dxc_reg  <= PB'(a_item_reg.dx) * PB'(a_cos_reg);
            b_dys_reg  <= PB'(a_item_reg.dy) * PB'(a_sin_reg);
            b_dxs_reg  <= PB'(a_item_reg.dx) * PB'(a_sin_reg);
            b_dyc_reg  <= PB'(a_item_reg.dy) * PB'(a_cos_reg);
        end
        if (b_valid_reg && c_ready)
        begin
            c_item_reg <= b_item_reg;
            c_rx_reg   <= rnd_x[QB-1:0];
            c_ry_reg   <= rnd_y[QB-1:0];
        end
        if (c_valid_reg && o_ready)
        begin
            heading_reg <= c_item_reg.heading;
        end
    end

    assign out_valid     = o_valid_reg;
    assign pos_x         = x_acc_reg;
    assign pos_y         = y_acc_reg;
    assign heading_angle = ofdr_pkg::angle_out(heading_reg);

endmodule

`default_nettype wire

@@ tb/optical_flow_dead_reckoning_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optical_flow_dead_reckoning_tb
// self-checking bench: a clocked driver feeds odometry items from a queue, a
// clocked monitor compares every result with a cordic-based position
// predictor, over several mounting angles and with random idling on both sides
// ----------------------------------------------------------------------------
module optical_flow_dead_reckoning_tb;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;       // comfortably above the depth of the pipe
    localparam int PHASE_ITEMS  = 220;
    localparam int HOLD_CYCLES  = 200;      // long enough to fill every stage

    // one input transaction, unpacked into its fields
    typedef struct {
        ofdr_pkg::mode_t    mode;
        logic [15:0]        yaw;
        logic               flow_valid;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [47:0]        set_value;
    } odo_item_t;

    // one result transaction
    typedef struct {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [15:0] heading;
    } odo_pos_t;

    // ------------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // yaw_angle, flow_dx, flow_dy, set_value
    logic [95:0] s_axis_tdata  = '0;
    // mode, flow_valid
    logic [2:0]  s_axis_tuser  = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // pos_x, pos_y, heading_angle
    wire [111:0] m_axis_tdata;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;

    optical_flow_dead_reckoning dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor state: our own copy of the odometry registers
    // ------------------------------------------------------------------------
    logic [47:0] x_pos_model   = '0;
    logic [47:0] y_pos_model   = '0;
    logic [15:0] yaw_ref_model = '0;
    logic [15:0] raw_yaw_model = '0;
    logic [15:0] heading_model = '0;
    logic [15:0] mount_model   = ofdr_pkg::MOUNT_RESET;
    bit          ref_latched   = 1'b0;

    odo_item_t pending_q[$];       // items waiting for the driver
    odo_pos_t  expected_q[$];      // predicted positions, oldest first

    // run control, written only by the stimulus process
    bit send_burst = 1'b0;         // sender offers back to back
    bit recv_burst = 1'b0;         // receiver never stalls
    bit hold_armed = 1'b0;         // ask the monitor for one long hold-off

    int fail_count  = 0;
    int sent_count  = 0;
    int seen_count  = 0;
    int cfg_writes  = 0;
    int cycle_count = 0;
    logic [15:0] yaw_walk = '0;

    // arctangent of 2^-i as a fraction of a 32-bit turn
    function automatic logic signed [63:0] arctan_turn(input int i);
        logic signed [63:0] r;
        case (i)
            0:  r = 64'h20000000;
            1:  r = 64'h12E4051E;
            2:  r = 64'h09FB385B;
            3:  r = 64'h051111D4;
            4:  r = 64'h028B0D43;
            5:  r = 64'h0145D7E1;
            6:  r = 64'h00A2F61E;
            7:  r = 64'h00517C55;
            8:  r = 64'h0028BE53;
            9:  r = 64'h00145F2F;
            10: r = 64'h000A2F98;
            11: r = 64'h000517CC;
            12: r = 64'h00028BE6;
            13: r = 64'h000145F3;
            14: r = 64'h0000A2FA;
            15: r = 64'h0000517D;
            16: r = 64'h000028BE;
            17: r = 64'h0000145F;
            18: r = 64'h00000A30;
            19: r = 64'h00000518;
            20: r = 64'h0000028C;
            21: r = 64'h00000146;
            22: r = 64'h000000A3;
            23: r = 64'h00000051;
            24: r = 64'h00000029;
            25: r = 64'h00000014;
            26: r = 64'h0000000A;
            27: r = 64'h00000005;
            28: r = 64'h00000003;
            29: r = 64'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    // rotate a flow step by a 16-bit binary angle, result in q.16 counts
    function automatic void rotate_flow(input logic [15:0] ang,
                                        input logic signed [15:0] dx,
                                        input logic signed [15:0] dy,
                                        output logic signed [63:0] rx,
                                        output logic signed [63:0] ry);
        logic [31:0]        turn;
        logic [31:0]        probe;
        logic               fold;
        logic signed [63:0] cx, sy, z, xs, ys, dxl, dyl;
        int                 i;
        turn  = {ang, 16'h0000};
        probe = turn + 32'h4000_0000;
        fold  = probe[31];
        // fold into +-quarter turn, undo by negating at the end
        if (fold)
            turn = turn + 32'h8000_0000;
        z  = 64'($signed(turn));
        cx = 64'sd652032874;
        sy = '0;
        for (i = 0; i < 30; i++)
        begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (z >= 0)
            begin
                cx = cx - ys;
                sy = sy + xs;
                z  = z - arctan_turn(i);
            end
            else
            begin
                cx = cx + ys;
                sy = sy - xs;
                z  = z + arctan_turn(i);
            end
        end
        if (fold)
        begin
            cx = -cx;
            sy = -sy;
        end
        dxl = 64'(dx);
        dyl = 64'(dy);
        // q30 down to 16 fraction bits, round half up
        rx = (dxl * cx - dyl * sy + 64'sd8192) >>> 14;
        ry = (dxl * sy + dyl * cx + 64'sd8192) >>> 14;
    endfunction

    // apply one item to the predictor state and return the new position
    function automatic odo_pos_t advance_odometry(input odo_item_t it);
        odo_pos_t           r;
        logic signed [63:0] rx, ry;
        case (it.mode)
            ofdr_pkg::MODE_SAMPLE:
            begin
                if (!ref_latched)
                begin
                    yaw_ref_model = it.yaw;
                    ref_latched   = 1'b1;
                end
                raw_yaw_model = it.yaw;
                heading_model = raw_yaw_model - yaw_ref_model;
                if (it.flow_valid)
                begin
                    rotate_flow(heading_model + mount_model, it.dx, it.dy, rx, ry);
                    y_pos_model = y_pos_model - rx[47:0];
                    x_pos_model = x_pos_model + ry[47:0];
                end
            end
            ofdr_pkg::MODE_SET_X:       x_pos_model   = it.set_value;
            ofdr_pkg::MODE_SET_Y:       y_pos_model   = it.set_value;
            ofdr_pkg::MODE_SET_HEADING: yaw_ref_model = raw_yaw_model - it.set_value[15:0];
            default:                    ;
        endcase
        r.pos_x   = x_pos_model;
        r.pos_y   = y_pos_model;
        r.heading = heading_model;
        return r;
    endfunction

    function automatic odo_item_t make_item(input ofdr_pkg::mode_t m, input logic [15:0] yaw,
                                            input logic fv, input logic [15:0] dx,
                                            input logic [15:0] dy,
                                            input logic [47:0] sv);
        odo_item_t it;
        it.mode       = m;
        it.yaw        = yaw;
        it.flow_valid = fv;
        it.dx         = dx;
        it.dy         = dy;
        it.set_value  = sv;
        return it;
    endfunction

    // mostly plausible motion: drifting yaw, modest flow, occasional sets
    function automatic odo_item_t random_item();
        odo_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.mode = ofdr_pkg::MODE_SAMPLE;
        else if (pick < 80)
            it.mode = ofdr_pkg::MODE_SET_X;
        else if (pick < 90)
            it.mode = ofdr_pkg::MODE_SET_Y;
        else
            it.mode = ofdr_pkg::MODE_SET_HEADING;
        yaw_walk = yaw_walk + 16'($urandom_range(0, 1023)) - 16'd512;
        it.yaw        = ($urandom_range(0, 7) == 0) ? 16'($urandom) : yaw_walk;
        it.flow_valid = ($urandom_range(0, 4) != 0);
        it.dx = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 255)) - 16'd128;
        it.dy = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 255)) - 16'd128;
        it.set_value = {16'($urandom), 32'($urandom)};
        // positions parked at the wrap points now and then
        if ($urandom_range(0, 9) == 0)
            it.set_value = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // driver: one item per transaction, random gap drawn per item
    // ------------------------------------------------------------------------
    odo_item_t drive_item;
    int        send_gap = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // input transaction completes: predict its result
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_q.push_back(advance_odometry(drive_item));
                sent_count++;
            end
            // slot is free after this edge, offer the next item or idle
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    drive_item = pending_q.pop_front();
                    s_axis_tdata <= {drive_item.set_value, drive_item.dy,
                                     drive_item.dx, drive_item.yaw};
                    s_axis_tuser <= {drive_item.flow_valid, drive_item.mode};
                    s_axis_tvalid <= 1'b1;
                    send_gap = send_burst ? 0 : $urandom_range(0, 9);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result transaction and paces tready
    // ------------------------------------------------------------------------
    odo_pos_t want_pos;
    int       recv_stall = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_count++;
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want_pos = expected_q.pop_front();
                    if (m_axis_tdata[47:0] !== want_pos.pos_x)
                    begin
                        $error("pos_x: expected %h, actual %h",
                               want_pos.pos_x, m_axis_tdata[47:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[95:48] !== want_pos.pos_y)
                    begin
                        $error("pos_y: expected %h, actual %h",
                               want_pos.pos_y, m_axis_tdata[95:48]);
                        fail_count++;
                    end
                    if (m_axis_tdata[111:96] !== want_pos.heading)
                    begin
                        $error("heading_angle: expected %h, actual %h",
                               want_pos.heading, m_axis_tdata[111:96]);
                        fail_count++;
                    end
                end
                recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
            end
            // single long hold-off so the pipe backs up into the input
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // mounting angle, only while nothing is in flight
    task automatic write_mount(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mount_model = value;
        cfg_writes++;
    endtask

    // sampled on the falling edge, clear of the clocked processes
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    endtask

    task automatic random_phase(input logic [15:0] mount, input bit sb, input bit rb,
                                input bit pressure);
        int n;
        write_mount(mount);
        @(negedge clk);
        send_burst = sb;
        recv_burst = rb;
        if (pressure)
            hold_armed = 1'b1;
        for (n = 0; n < PHASE_ITEMS; n++)
            pending_q.push_back(random_item());
        wait_drained();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items under the reset mounting angle
        // sets ahead of the first sample, junk in the ignored fields
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_X, 16'hFFFF, 1'b1, 16'h7FFF,
                                      16'h8000, 48'h7FFF_FFFF_FFF0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_HEADING, 16'h5555, 1'b1, 16'hAAAA,
                                      16'h5555, 48'hFFFF_FFFF_1234));
        // first sample latches the reference, heading zero
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF,
                                      16'h8000, 48'hFFFF_FFFF_FFFF));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h8000, 1'b1, 16'h8000,
                                      16'h8000, 48'h0));
        // flow fields present but not flagged
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h4000, 1'b0, 16'h1234,
                                      16'h5678, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_Y, 16'h0, 1'b0, 16'h0, 16'h0,
                                      48'h8000_0000_0000));
        // y moved up away from its minimum
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'hC000, 1'b1, 16'h7FFF,
                                      16'h7FFF, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_HEADING, 16'hFFFF, 1'b1, 16'hFFFF,
                                      16'hFFFF, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'hC000, 1'b1, 16'h0001,
                                      16'h0000, 48'h0));
        // heading set to half a turn
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_HEADING, 16'h0, 1'b0, 16'h0, 16'h0,
                                      48'h0000_0000_8000));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h0000, 1'b1, 16'h0000,
                                      16'hFFFF, 48'h0));
        // yaw values around the quarter turns
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h3FFF, 1'b1, 16'h8000,
                                      16'h7FFF, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h4001, 1'b1, 16'h7FFF,
                                      16'h8000, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'hBFFF, 1'b1, 16'h4000,
                                      16'hC000, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_X, 16'h0, 1'b0, 16'h0, 16'h0,
                                      48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_Y, 16'h0, 1'b0, 16'h0, 16'h0,
                                      48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'hFFFF, 1'b1, 16'h0000,
                                      16'h0000, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SET_HEADING, 16'h0, 1'b0, 16'h0, 16'h0,
                                      48'hFFFF_FFFF_FFFF));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h0001, 1'b1, 16'hFFFF,
                                      16'h0001, 48'h0));
        pending_q.push_back(make_item(ofdr_pkg::MODE_SAMPLE, 16'h8001, 1'b1, 16'h4000,
                                      16'hC000, 48'hAAAA_AAAA_AAAA));
        wait_drained();

        // random phases: zero, both extremes, a random angle, back to default
        random_phase(16'h0000, 1'b1, 1'b1, 1'b0);                // no idling at all
        random_phase(16'h7FFF, 1'b1, 1'b0, 1'b1);                // long output hold-off
        random_phase(16'h8000, 1'b0, 1'b0, 1'b0);
        random_phase(16'($urandom), 1'b0, 1'b1, 1'b0);
        random_phase(ofdr_pkg::MOUNT_RESET, 1'b0, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d input and %0d result transactions, all modes, %0d mount angles",
                 sent_count, seen_count, cfg_writes);
        $display("with back-to-back, random-idle and %0d-cycle output hold-off phases",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

endmodule
